FILE: rtl/assert_macros.svh
// Assertion helpers for the checker of this block.
// Each checker that uses them provides clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle rule: when ante holds, cons holds too.
`define ABR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle rule: when ante holds, cons holds in the cycle after.
`define ABR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/abr_trs_pkg.sv
package abr_trs_pkg;

	// field widths
	localparam int OP_W    = 2;
	localparam int SEG_W   = 32;
	localparam int BYTES_W = 32;
	localparam int TIME_W  = 40;
	localparam int IDX_W   = 3;
	localparam int RATE_W  = 32;
	localparam int LEVEL_W = 3;
	localparam int CASE_W  = 2;

	// bytes per microsecond to bits per second
	localparam int SCALE_W = 24;
	localparam logic [SCALE_W-1:0] BITS_SCALE = 24'd8000000;

	typedef logic [OP_W-1:0]    op_t;
	typedef logic [LEVEL_W-1:0] level_t;
	typedef logic [CASE_W-1:0]  case_t;

	// request operations
	localparam op_t OP_RECORD = 2'd0;
	localparam op_t OP_DECIDE = 2'd1;
	localparam op_t OP_LOAD   = 2'd2;

	// decision cases
	localparam case_t CASE_STARTUP  = 2'd0;
	localparam case_t CASE_STAY     = 2'd1;
	localparam case_t CASE_INCREASE = 2'd2;
	localparam case_t CASE_DECREASE = 2'd3;

	typedef struct packed {
		op_t                op;
		logic [SEG_W-1:0]   segment_number;
		logic [BYTES_W-1:0] bytes_received;
		logic [TIME_W-1:0]  start_time_us;
		logic [TIME_W-1:0]  end_time_us;
		logic [IDX_W-1:0]   ladder_index;
		logic [RATE_W-1:0]  ladder_bitrate;
	} req_t;

	typedef struct packed {
		level_t next_level;
		case_t  decision_case;
	} rsp_t;

endpackage

FILE: rtl/abr_trs_ram.sv
module abr_trs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port, registered read port (old data on a same-address write)
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/abr_throughput_rate_step.sv
// A decide request passes the request register, then the result register;
// record and load give none. Throughput: one request per cycle unless a
// decide waits on a stalled result; the window sums are kept running, so
// the decision is two split bitrate-by-duration products and two compares.
// Reset (arst_n low): level, window, sums, write slot and highest level go
// to zero at once; ladder entries hold nothing until loaded.
module abr_throughput_rate_step #(
	parameter int MAX_LEVELS = 8,
	parameter int WINDOW_LEN = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  abr_trs_pkg::req_t     req,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output abr_trs_pkg::rsp_t     rsp,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  abr_trs_pkg::level_t   cfg_data
);

	import abr_trs_pkg::*;

	localparam int SLOT_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int ADDR_W  = $clog2(MAX_LEVELS);
	localparam int SB_W    = BYTES_W + $clog2(WINDOW_LEN);
	localparam int SD_W    = TIME_W + $clog2(WINDOW_LEN);
	localparam int SD_HI_W = SD_W - RATE_W;
	localparam int PROD_W  = RATE_W + SD_W;
	localparam int THR_W   = SB_W + SCALE_W;

	// request register
	logic valid_s1;
	req_t req_s1;

	// result register
	logic rsp_valid_q;
	rsp_t rsp_q;

	// block state
	level_t             cur_q;
	level_t             highest_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [SB_W-1:0]    sum_bytes_q;
	logic [SD_W-1:0]    sum_dur_q;
	logic [BYTES_W-1:0] win_bytes_q [WINDOW_LEN];
	logic [TIME_W-1:0]  win_dur_q [WINDOW_LEN];

	// ladder read bypass
	logic              fwd_cur_q;
	logic              fwd_up_q;
	logic [RATE_W-1:0] ladder_wd_q;

	logic              is_decide;
	logic              is_record;
	logic              is_load;
	logic              adv_s1;
	logic              accept;

	logic [TIME_W-1:0] dur;
	logic [SB_W-1:0]   sum_bytes_d;
	logic [SD_W-1:0]   sum_dur_d;
	logic [SLOT_W-1:0] slot_nx;

	level_t             top;
	logic [RATE_W-1:0]  ram_cur_rd;
	logic [RATE_W-1:0]  ram_up_rd;
	logic [RATE_W-1:0]  rate_cur;
	logic [RATE_W-1:0]  rate_up;
	logic [THR_W-1:0]   thr;
	logic [2*RATE_W-1:0]        pc_lo;
	logic [2*RATE_W-1:0]        pu_lo;
	logic [RATE_W+SD_HI_W-1:0]  pc_hi;
	logic [RATE_W+SD_HI_W-1:0]  pu_hi;
	logic [PROD_W-1:0]  prod_cur;
	logic [PROD_W-1:0]  prod_up;
	logic               up_ok;
	logic               dn_ok;
	logic               empty;
	logic               startup;
	rsp_t               dec;

	level_t             cur_d;
	logic [LEVEL_W:0]   up_d;
	logic [ADDR_W-1:0]  rd_cur_addr;
	logic [ADDR_W-1:0]  rd_up_addr;
	logic               ld_en;
	logic [ADDR_W-1:0]  ld_addr;

	// handshake
	assign is_decide = (req_s1.op == OP_DECIDE);
	assign is_record = (req_s1.op == OP_RECORD);
	assign is_load   = (req_s1.op == OP_LOAD);
	assign adv_s1    = valid_s1 && (!is_decide || !rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !adv_s1;
	assign accept    = req_valid && !req_stall;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// window update: replace the oldest download in the running sums
	always_comb begin
		dur = (req_s1.end_time_us >= req_s1.start_time_us) ?
			req_s1.end_time_us - req_s1.start_time_us : '0;
		sum_bytes_d = sum_bytes_q - SB_W'(win_bytes_q[slot_q])
			+ SB_W'(req_s1.bytes_received);
		sum_dur_d = sum_dur_q - SD_W'(win_dur_q[slot_q]) + SD_W'(dur);
		slot_nx = (slot_q == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_q + 1'b1;
	end

	// throughput compare against the ladder
	always_comb begin
		top = (int'(highest_q) > MAX_LEVELS - 1) ? LEVEL_W'(MAX_LEVELS - 1) : highest_q;
		rate_cur = fwd_cur_q ? ladder_wd_q : ram_cur_rd;
		rate_up  = fwd_up_q ? ladder_wd_q : ram_up_rd;
		thr = THR_W'(sum_bytes_q) * THR_W'(BITS_SCALE);
		pc_lo = rate_cur * sum_dur_q[RATE_W-1:0];
		pu_lo = rate_up * sum_dur_q[RATE_W-1:0];
		pc_hi = rate_cur * sum_dur_q[SD_W-1:RATE_W];
		pu_hi = rate_up * sum_dur_q[SD_W-1:RATE_W];
		prod_cur = PROD_W'(pc_lo) + (PROD_W'(pc_hi) << RATE_W);
		prod_up  = PROD_W'(pu_lo) + (PROD_W'(pu_hi) << RATE_W);
		up_ok = (cur_q < top) && (prod_up <= PROD_W'(thr));
		dn_ok = (cur_q != '0) && (prod_cur >= PROD_W'(thr));
		empty = (sum_bytes_q == '0) && (sum_dur_q == '0);
		startup = (req_s1.segment_number < SEG_W'(WINDOW_LEN));
	end

	// decision
	always_comb begin
		if (startup) begin
			dec.next_level    = '0;
			dec.decision_case = CASE_STARTUP;
		end else if (empty) begin
			dec.next_level    = cur_q;
			dec.decision_case = CASE_STAY;
		end else if (up_ok) begin
			dec.next_level    = cur_q + 1'b1;
			dec.decision_case = CASE_INCREASE;
		end else if (dn_ok) begin
			dec.next_level    = cur_q - 1'b1;
			dec.decision_case = CASE_DECREASE;
		end else begin
			dec.next_level    = cur_q;
			dec.decision_case = CASE_STAY;
		end
	end

	// ladder read addresses follow the level of the next cycle
	always_comb begin
		cur_d = (adv_s1 && is_decide) ? dec.next_level : cur_q;
		up_d = {1'b0, cur_d} + 1'b1;
		rd_cur_addr = ADDR_W'(cur_d);
		rd_up_addr  = ADDR_W'(up_d);
		ld_en   = adv_s1 && is_load && (int'(req_s1.ladder_index) < MAX_LEVELS);
		ld_addr = ADDR_W'(req_s1.ladder_index);
	end

	abr_trs_ram #(
		.WIDTH (RATE_W),
		.DEPTH (MAX_LEVELS)
	) u_ladder_cur (
		.clk   (clk),
		.we    (ld_en),
		.waddr (ld_addr),
		.wdata (req_s1.ladder_bitrate),
		.raddr (rd_cur_addr),
		.rdata (ram_cur_rd)
	);

	abr_trs_ram #(
		.WIDTH (RATE_W),
		.DEPTH (MAX_LEVELS)
	) u_ladder_up (
		.clk   (clk),
		.we    (ld_en),
		.waddr (ld_addr),
		.wdata (req_s1.ladder_bitrate),
		.raddr (rd_up_addr),
		.rdata (ram_up_rd)
	);

	// control and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
			cur_q       <= '0;
			highest_q   <= '0;
			slot_q      <= '0;
			sum_bytes_q <= '0;
			sum_dur_q   <= '0;
			fwd_cur_q   <= 1'b0;
			fwd_up_q    <= 1'b0;
			for (int i = 0; i < WINDOW_LEN; i++) begin
				win_bytes_q[i] <= '0;
				win_dur_q[i]   <= '0;
			end
		end else begin
			// advance the request register
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			// load or drop the result
			if (adv_s1 && is_decide) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			cur_q <= cur_d;
			if (cfg_valid && cfg_ready) begin
				highest_q <= cfg_data;
			end
			// record a finished download
			if (adv_s1 && is_record) begin
				win_bytes_q[slot_q] <= req_s1.bytes_received;
				win_dur_q[slot_q]   <= dur;
				sum_bytes_q         <= sum_bytes_d;
				sum_dur_q           <= sum_dur_d;
				slot_q              <= slot_nx;
			end
			// bypass a ladder write to the address read in the same cycle
			fwd_cur_q <= ld_en && (ld_addr == rd_cur_addr);
			fwd_up_q  <= ld_en && (ld_addr == rd_up_addr);
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
		if (adv_s1 && is_decide) begin
			rsp_q <= dec;
		end
		ladder_wd_q <= req_s1.ladder_bitrate;
	end

endmodule

FILE: rtl/abr_trs_chk.sv
module abr_trs_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input abr_trs_pkg::rsp_t rsp
);

	import abr_trs_pkg::*;

	`include "assert_macros.svh"

	level_t prev_q;

	// track the level of the last delivered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (rsp_valid && !rsp_stall) begin
			prev_q <= rsp.next_level;
		end
	end

	`ABR_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled result changed")
	`ABR_ASSERT_NOW(a_startup_zero, rsp_valid && rsp.decision_case == CASE_STARTUP, rsp.next_level == '0, "startup level not zero")
	`ABR_ASSERT_NOW(a_stay_level, rsp_valid && rsp.decision_case == CASE_STAY, rsp.next_level == prev_q, "stay moved the level")
	`ABR_ASSERT_NOW(a_up_level, rsp_valid && rsp.decision_case == CASE_INCREASE, 4'(rsp.next_level) == 4'(prev_q) + 4'd1, "increase not one step up")
	`ABR_ASSERT_NOW(a_down_level, rsp_valid && rsp.decision_case == CASE_DECREASE, 4'(rsp.next_level) + 4'd1 == 4'(prev_q), "decrease not one step down")

endmodule

bind abr_throughput_rate_step abr_trs_chk u_abr_trs_chk (.*);
